[sv/smallest_free_id_allocator_unit_assert.svh]
`ifndef SMALLEST_FREE_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define SMALLEST_FREE_ID_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SFID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sfid check failed");

// next-cycle implication
`define SFID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sfid check failed");

`endif

[sv/sfid_pkg.sv]
`timescale 1ns / 1ps

package sfid_pkg;

  localparam int unsigned IDENT_W = 10;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               action;
    logic [IDENT_W-1:0] ident;
  } sfid_req_t;

  typedef struct packed {
    logic               valid;
    logic [IDENT_W-1:0] alloc_ident;
    logic               ok;
  } sfid_rsp_t;

endpackage

[sv/sfid_heap_core.sv]
`timescale 1ns / 1ps

`include "smallest_free_id_allocator_unit_assert.svh"

module sfid_heap_core #(
  parameter int unsigned NUM_IDS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfid_pkg::sfid_req_t req_i,
  output logic              req_ready_o,
  output sfid_pkg::sfid_rsp_t rsp_o,
  input  logic              rsp_ready_i
);

  localparam int unsigned POS_W = $clog2(NUM_IDS);
  localparam int unsigned CNT_W = $clog2(NUM_IDS + 1);
  localparam int unsigned LW    = POS_W + 2;
  localparam int unsigned VAL_W = (POS_W > sfid_pkg::IDENT_W) ? POS_W : sfid_pkg::IDENT_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_IDS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_IDS);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AL_TAKE,
    ST_SD_RD,
    ST_SD_CMP,
    ST_SU_RD,
    ST_SU_CMP,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [POS_W-1:0]  pos_q;
  logic [VAL_W-1:0]  x_q;
  logic [VAL_W-1:0]  res_ident_q;
  logic              res_ok_q;

  logic [VAL_W-1:0]  mem [NUM_IDS];
  logic [VAL_W-1:0]  rd0_q, rd1_q;
  logic [POS_W-1:0]  ra0, ra1, wa;
  logic [VAL_W-1:0]  wd;
  logic              we;

  logic [LW-1:0]     left_idx, right_idx, cnt_ext;
  logic [POS_W-1:0]  parent;
  logic              left_ok, right_ok, take_l, take_r, up_swap;
  logic [VAL_W-1:0]  best_val;
  logic              start;

  // heap index arithmetic
  assign left_idx  = {1'b0, pos_q, 1'b1};
  assign right_idx = left_idx + 1'b1;
  assign cnt_ext   = LW'(cnt_q);
  assign parent    = POS_W'((pos_q - 1'b1) >> 1);
  assign left_ok   = left_idx < cnt_ext;
  assign right_ok  = right_idx < cnt_ext;
  assign take_l    = left_ok && (rd0_q < x_q);
  assign best_val  = take_l ? rd0_q : x_q;
  assign take_r    = right_ok && (rd1_q < best_val);
  assign up_swap   = x_q < rd0_q;

  assign start       = req_i.valid && (state_q == ST_IDLE);
  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    ra0 = '0;
    ra1 = '0;
    we  = 1'b0;
    wa  = pos_q;
    wd  = x_q;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        wd = VAL_W'(pos_q);
      end
      ST_IDLE: begin
        ra1 = POS_W'(cnt_q - 1'b1);
      end
      ST_SD_RD: begin
        ra0 = left_idx[POS_W-1:0];
        ra1 = right_idx[POS_W-1:0];
      end
      ST_SD_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wd = rd1_q;
        end else if (take_l) begin
          wd = rd0_q;
        end
      end
      ST_SU_RD: begin
        ra0 = parent;
        we  = (pos_q == '0);
      end
      ST_SU_CMP: begin
        we = 1'b1;
        wd = up_swap ? rd0_q : x_q;
      end
      default: begin
      end
    endcase
  end

  // heap store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= FULL_CNT;
      pos_q       <= '0;
      x_q         <= '0;
      res_ident_q <= '0;
      res_ok_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          pos_q <= pos_q + 1'b1;
          if (pos_q == LAST_POS) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            res_ident_q <= '0;
            res_ok_q    <= 1'b0;
            if (req_i.action == sfid_pkg::ACT_ALLOC) begin
              state_q <= (cnt_q == '0) ? ST_DONE : ST_AL_TAKE;
            end else if (cnt_q == FULL_CNT) begin
              state_q <= ST_DONE;
            end else begin
              x_q      <= VAL_W'(req_i.ident);
              pos_q    <= POS_W'(cnt_q);
              cnt_q    <= cnt_q + 1'b1;
              res_ok_q <= 1'b1;
              state_q  <= ST_SU_RD;
            end
          end
        end
        ST_AL_TAKE: begin
          res_ident_q <= rd0_q;
          res_ok_q    <= 1'b1;
          x_q         <= rd1_q;
          pos_q       <= '0;
          cnt_q       <= cnt_q - 1'b1;
          state_q     <= (cnt_q == CNT_W'(1)) ? ST_DONE : ST_SD_RD;
        end
        ST_SD_RD: begin
          state_q <= ST_SD_CMP;
        end
        ST_SD_CMP: begin
          if (take_r) begin
            pos_q   <= right_idx[POS_W-1:0];
            state_q <= ST_SD_RD;
          end else if (take_l) begin
            pos_q   <= left_idx[POS_W-1:0];
            state_q <= ST_SD_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SU_RD: begin
          state_q <= (pos_q == '0) ? ST_DONE : ST_SU_CMP;
        end
        ST_SU_CMP: begin
          if (up_swap) begin
            pos_q   <= parent;
            state_q <= ST_SU_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = (state_q == ST_DONE);
  assign rsp_o.alloc_ident = res_ident_q[sfid_pkg::IDENT_W-1:0];
  assign rsp_o.ok          = res_ok_q;

  `SFID_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= FULL_CNT)
  `SFID_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start, state_q != ST_IDLE)
  `SFID_ASSERT_NEXT(a_alloc_dec, clk_i, rst_ni, state_q == ST_AL_TAKE, cnt_q == $past(cnt_q) - 1'b1)
  `SFID_ASSERT_NOW(a_idle_no_write, clk_i, rst_ni, state_q == ST_IDLE || state_q == ST_DONE, !we)

endmodule

[sv/smallest_free_id_allocator_unit.sv]
`timescale 1ns / 1ps

// Smallest-free-identifier allocator. After reset the block runs a clearing pass
// that loads the heap with every identifier, and in_ready_o stays low meanwhile.
// An allocate word returns the smallest free identifier (ok_o high) or ok_o low
// when none is free; a release word stores ident_i (ok_o high) or drops it when
// the pool is full. Releases are not checked for duplicates. One word at a time is
// worked: each level of the sift up or sift down waits for the registered read of
// the single heap memory. A finished result sits in an output register, so the
// next word can be taken while it waits.
module smallest_free_id_allocator_unit #(
  parameter int unsigned NUM_IDS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             action_i,
  input  logic [sfid_pkg::IDENT_W-1:0]     ident_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sfid_pkg::IDENT_W-1:0]     alloc_ident_o,
  output logic                             ok_o
);

  sfid_pkg::sfid_req_t req;
  sfid_pkg::sfid_rsp_t rsp;
  logic                rsp_ready;
  logic                out_valid_q;
  logic [sfid_pkg::IDENT_W-1:0] alloc_ident_q;
  logic                ok_q;

  assign req.valid  = in_valid_i;
  assign req.action = action_i;
  assign req.ident  = ident_i;

  sfid_heap_core #(
    .NUM_IDS(NUM_IDS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .req_ready_o(in_ready_o),
    .rsp_o      (rsp),
    .rsp_ready_i(rsp_ready)
  );

  // output word register
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp.valid) begin
      alloc_ident_q <= rsp.alloc_ident;
      ok_q          <= rsp.ok;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign alloc_ident_o = alloc_ident_q;
  assign ok_o          = ok_q;

endmodule

[verif/smallest_free_id_allocator_unit_tb.sv]
`timescale 1ns / 1ps

module smallest_free_id_allocator_unit_tb;

  localparam int unsigned IDENT_W      = sfid_pkg::IDENT_W;
  localparam int unsigned NUM_IDS      = 1024;
  localparam int unsigned RANDOM_WORDS = 64;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [IDENT_W-1:0] alloc_ident;
    logic               ok;
  } alloc_result_t;

  // free ids kept as a count per id, the smallest id with a nonzero count is handed out
  class id_pool_scoreboard;
    int unsigned   free_copies[NUM_IDS];
    int unsigned   pool_size;
    alloc_result_t expected_q[$];
    int unsigned   mismatches;

    function new();
      for (int i = 0; i < NUM_IDS; i++) begin
        free_copies[i] = 1;
      end
      pool_size  = NUM_IDS;
      mismatches = 0;
    endfunction

    function void note_word(logic act, logic [IDENT_W-1:0] id);
      alloc_result_t exp_r;
      int unsigned   slot;
      exp_r = '0;
      if (act == sfid_pkg::ACT_ALLOC) begin
        if (pool_size > 0) begin
          slot = 0;
          while (free_copies[slot] == 0) slot++;
          free_copies[slot]--;
          pool_size--;
          exp_r.alloc_ident = slot[IDENT_W-1:0];
          exp_r.ok          = 1'b1;
        end
      end else if (pool_size < NUM_IDS) begin
        free_copies[id]++;
        pool_size++;
        exp_r.ok = 1'b1;
      end
      expected_q.push_back(exp_r);
    endfunction

    function void check_word(logic [IDENT_W-1:0] got_ident, logic got_ok);
      alloc_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: result with none pending: alloc_ident=%0d ok=%b",
                   $realtime, got_ident, got_ok);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got_ident !== exp_r.alloc_ident || got_ok !== exp_r.ok) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: mismatch alloc_ident exp %0d got %0d, ok exp %b got %b",
                   $realtime, exp_r.alloc_ident, got_ident, exp_r.ok, got_ok);
      end
    endfunction

    function void flag_leftover();
      if (expected_q.size() != 0) begin
        mismatches++;
        $display("%0t: %0d results never arrived", $realtime, expected_q.size());
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic [IDENT_W-1:0] ident;
  logic               out_valid;
  logic               out_ready;
  logic [IDENT_W-1:0] alloc_ident;
  logic               ok;
  logic               quiet;

  id_pool_scoreboard sb = new();

  smallest_free_id_allocator_unit #(
    .NUM_IDS(NUM_IDS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .ident_i       (ident),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .alloc_ident_o (alloc_ident),
    .ok_o          (ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_word(input logic act, input logic [IDENT_W-1:0] id);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action   = act;
    ident    = id;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(act, id);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [IDENT_W-1:0] pick_ident();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10)
      return ($urandom_range(0, 1) != 0) ? {IDENT_W{1'b1}} : {IDENT_W{1'b0}};
    else if (roll < 35)
      return IDENT_W'($urandom_range(0, 15));
    else
      return IDENT_W'($urandom_range(0, NUM_IDS - 1));
  endfunction

  // result side
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    do @(negedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_word(alloc_ident, ok);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned seg_left;
    int unsigned alloc_pct;
    in_valid  = 1'b0;
    action    = sfid_pkg::ACT_ALLOC;
    ident     = '0;
    quiet     = 1'b0;
    rst_n     = 1'b0;
    sent      = 0;
    seg_left  = 0;
    alloc_pct = 50;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // release into a full pool, then small ids and duplicates
    send_word(sfid_pkg::ACT_RELEASE, 10'd1023);
    send_word(sfid_pkg::ACT_RELEASE, 10'd0);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_RELEASE, 10'd1);
    send_word(sfid_pkg::ACT_RELEASE, 10'd1);
    send_word(sfid_pkg::ACT_RELEASE, 10'd0);
    send_word(sfid_pkg::ACT_RELEASE, 10'd1023);
    send_word(sfid_pkg::ACT_ALLOC, 10'd1023);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_RELEASE, 10'd1023);
    send_word(sfid_pkg::ACT_RELEASE, 10'd512);
    send_word(sfid_pkg::ACT_RELEASE, 10'd341);
    send_word(sfid_pkg::ACT_RELEASE, 10'd682);

    // drain to empty, then allocate from an empty pool
    while (sb.pool_size > 0) send_word(sfid_pkg::ACT_ALLOC, pick_ident());
    send_word(sfid_pkg::ACT_ALLOC, 10'd1023);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_RELEASE, 10'd1023);
    send_word(sfid_pkg::ACT_RELEASE, 10'd0);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    send_word(sfid_pkg::ACT_ALLOC, 10'd0);
    wait_idle();

    while (sent < RANDOM_WORDS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0: alloc_pct = 15;
          1: alloc_pct = 50;
          default: alloc_pct = 85;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (sent == RANDOM_WORDS / 2) wait_idle();
      send_word(($urandom_range(1, 100) <= alloc_pct) ? sfid_pkg::ACT_ALLOC
                                                      : sfid_pkg::ACT_RELEASE,
                pick_ident());
      sent++;
      seg_left--;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftover();
    if (sb.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
